[rtl/handle_table_free_list_top_assert.svh]
// Assertion macros for the handle table free list checker.
// Depends on nothing; expects signals clk and arst_n in the using scope.
`ifndef HANDLE_TABLE_FREE_LIST_TOP_ASSERT_SVH
`define HANDLE_TABLE_FREE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset
`define HFT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset
`define HFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/hft_pkg.sv]
// Shared types and codes for the handle table free list block.
// Used by every module of the block and by its checker; depends on nothing.
package hft_pkg;

	// Default number of table entries
	localparam int TABLE_SIZE_DEF = 256;

	// End mark of the free list
	localparam logic [31:0] LINK_END = 32'hFFFF_FFFF;

	// Action codes
	localparam logic [1:0] ACT_INSERT    = 2'd0;
	localparam logic [1:0] ACT_REFERENCE = 2'd1;
	localparam logic [1:0] ACT_CLOSE     = 2'd2;
	localparam logic [1:0] ACT_CHECK     = 2'd3;

	// Status codes
	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_INVALID = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_TYPE    = 3'd3;
	localparam logic [2:0] STAT_DENIED  = 3'd4;

	// Reference-count event codes
	localparam logic [1:0] EV_NONE        = 2'd0;
	localparam logic [1:0] EV_HANDLE_UP   = 2'd1;
	localparam logic [1:0] EV_REFERENCED  = 2'd2;
	localparam logic [1:0] EV_HANDLE_DOWN = 2'd3;

	// One table entry: object id (0 = free), type, and next link or granted access
	typedef struct packed {
		logic [31:0] object_id;
		logic [7:0]  object_type;
		logic [31:0] link_or_access;
	} entry_t;

	// Command payload
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] handle;
		logic [31:0] object_id;
		logic [7:0]  object_type;
		logic [31:0] access_mask;
	} cmd_t;

	// Result payload
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  handle_out;
		logic [31:0] object_out;
		logic [31:0] granted_access;
		logic [1:0]  count_event;
	} result_t;

endpackage

[rtl/hft_ram.sv]
// Entry memory of the handle table: one write port, one registered read port.
// Depends on hft_pkg for the entry type.
module hft_ram #(
	parameter int DEPTH  = hft_pkg::TABLE_SIZE_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  hft_pkg::entry_t     wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output hft_pkg::entry_t     rdata
);

	hft_pkg::entry_t mem [DEPTH];
	hft_pkg::entry_t rdata_q;

	// Write and read the entry array; read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/hft_ctrl.sv]
// Sequencer of the handle table: clearing pass after reset, then one
// read-modify-write of the entry memory and free head per command.
// Depends on hft_pkg; drives the ports of hft_ram.
module hft_ctrl #(
	parameter int TABLE_SIZE = hft_pkg::TABLE_SIZE_DEF,
	parameter int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  hft_pkg::cmd_t       cmd,
	output logic                done,
	output hft_pkg::result_t    result,
	output logic                ram_we,
	output logic [IDX_W-1:0]    ram_waddr,
	output hft_pkg::entry_t     ram_wdata,
	output logic                ram_re,
	output logic [IDX_W-1:0]    ram_raddr,
	input  hft_pkg::entry_t     ram_rdata
);

	localparam int               HEAD_W   = $clog2(TABLE_SIZE + 1);
	localparam logic [HEAD_W-1:0] HEAD_END = HEAD_W'(TABLE_SIZE);
	localparam logic [31:0]      SIZE_32  = 32'(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    init_cnt_q;
	logic [HEAD_W-1:0]   free_head_q;
	hft_pkg::cmd_t       cmd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                in_range_s1;
	logic                done_q;
	hft_pkg::result_t    result_q;

	logic                accept;
	logic                entry_valid;
	logic                head_empty;
	logic [HEAD_W-1:0]   head_d;
	logic                exec_we;
	hft_pkg::entry_t     exec_wdata;
	hft_pkg::result_t    result_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Address the entry the command touches: free head for insert, handle otherwise
	assign ram_re    = accept;
	assign ram_raddr = (cmd.action == hft_pkg::ACT_INSERT) ? free_head_q[IDX_W-1:0]
	                                                       : cmd.handle[IDX_W-1:0];

	assign entry_valid = in_range_s1 && (ram_rdata.object_id != 32'd0);
	assign head_empty  = (free_head_q == HEAD_END);

	// Work out the result, the write-back and the new free head
	always_comb begin
		result_d   = '0;
		head_d     = free_head_q;
		exec_we    = 1'b0;
		exec_wdata = ram_rdata;
		case (cmd_s1.action)
			hft_pkg::ACT_INSERT: begin
				if (cmd_s1.object_id == 32'd0) begin
					result_d.status = hft_pkg::STAT_INVALID;
				end else if (head_empty) begin
					result_d.status = hft_pkg::STAT_FULL;
				end else begin
					exec_we                   = 1'b1;
					exec_wdata.object_id      = cmd_s1.object_id;
					exec_wdata.object_type    = cmd_s1.object_type;
					exec_wdata.link_or_access = cmd_s1.access_mask;
					head_d = (ram_rdata.link_or_access >= SIZE_32) ? HEAD_END
					       : ram_rdata.link_or_access[HEAD_W-1:0];
					result_d.handle_out  = 8'(idx_s1);
					result_d.object_out  = cmd_s1.object_id;
					result_d.count_event = hft_pkg::EV_HANDLE_UP;
				end
			end
			hft_pkg::ACT_REFERENCE: begin
				if (!entry_valid) begin
					result_d.status = hft_pkg::STAT_INVALID;
				end else if ((cmd_s1.object_type != 8'd0) &&
				             (ram_rdata.object_type != cmd_s1.object_type)) begin
					result_d.status = hft_pkg::STAT_TYPE;
				end else begin
					result_d.object_out  = ram_rdata.object_id;
					result_d.count_event = hft_pkg::EV_REFERENCED;
				end
			end
			hft_pkg::ACT_CLOSE: begin
				if (!entry_valid) begin
					result_d.status = hft_pkg::STAT_INVALID;
				end else begin
					exec_we                   = 1'b1;
					exec_wdata.object_id      = 32'd0;
					exec_wdata.link_or_access = head_empty ? hft_pkg::LINK_END
					                                       : 32'(free_head_q);
					head_d = HEAD_W'(idx_s1);
					result_d.object_out  = ram_rdata.object_id;
					result_d.count_event = hft_pkg::EV_HANDLE_DOWN;
				end
			end
			default: begin
				result_d.granted_access = entry_valid ? ram_rdata.link_or_access : 32'd0;
				if ((result_d.granted_access & cmd_s1.access_mask) != cmd_s1.access_mask) begin
					result_d.status = hft_pkg::STAT_DENIED;
				end
			end
		endcase
	end

	// Drive the write port: chained free list during the clearing pass, else write-back
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = exec_wdata;
		if (state_q == S_INIT) begin
			ram_we                   = 1'b1;
			ram_waddr                = init_cnt_q;
			ram_wdata.object_id      = 32'd0;
			ram_wdata.object_type    = 8'd0;
			ram_wdata.link_or_access = (init_cnt_q == LAST_IDX) ? hft_pkg::LINK_END
			                                                    : 32'(init_cnt_q) + 32'd1;
		end else if (state_q == S_EXEC) begin
			ram_we = exec_we;
		end
	end

	// Sequence clearing pass, accept and execute; hold the free head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			free_head_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					free_head_q <= head_d;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the command at transfer and the result after execution
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			idx_s1      <= ram_raddr;
			in_range_s1 <= (32'(cmd.handle) < SIZE_32);
		end
		if (state_q == S_EXEC) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/handle_table_free_list_top.sv]
// Top level of the handle table with a linked free list.
// Depends on hft_pkg, hft_ram and hft_ctrl.
//
// Usage:
//   Command channel: drive cmd and raise start; the command transfers at the
//   rising edge where start is high and busy is low. busy stays high while a
//   command executes and during the clearing pass after reset.
//   Result channel: done is high for exactly one cycle with result valid; the
//   result transfers at the edge ending that cycle. There is no back-pressure.
//   Sequence: the entry memory is read at the transfer edge; execute and
//   write-back take the execute state, whose end registers done and result.
//   Each command makes a single read-modify-write of the entry memory; a new
//   command may transfer in the same cycle as the previous result is shown.
//   Reset: arst_n clears the control state, then a clearing pass writes every
//   entry as free and chains the free list in index order, one entry per
//   cycle; busy is high throughout.
module handle_table_free_list_top #(
	parameter int TABLE_SIZE = hft_pkg::TABLE_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hft_pkg::cmd_t     cmd,
	output logic              done,
	output hft_pkg::result_t  result
);

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	hft_pkg::entry_t   ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	hft_pkg::entry_t   ram_rdata;

	// Sequencer and free head
	hft_ctrl #(
		.TABLE_SIZE (TABLE_SIZE),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Entry memory
	hft_ram #(
		.DEPTH  (TABLE_SIZE),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[rtl/hft_checker.sv]
// Port-level checker for the handle table, bound to the top level.
// Depends on hft_pkg and handle_table_free_list_top_assert.svh.
`include "handle_table_free_list_top_assert.svh"

module hft_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input hft_pkg::result_t  result
);

	// A transfer keeps the block busy for the execute cycle
	`HFT_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy, "no busy after transfer")

	// A result strobe lasts one cycle
	`HFT_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")

	// A result follows a busy cycle and frees the command side
	`HFT_ASSERT_SAME(a_done_after_busy, done, $past(busy) && !busy, "result without execution")

	// A failed command raises no count event
	`HFT_ASSERT_SAME(a_fail_no_event, done && (result.status != hft_pkg::STAT_OK), result.count_event == hft_pkg::EV_NONE, "count event on failure")

endmodule

bind handle_table_free_list_top hft_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
